>>> hw/rtl/checksummed_frame_receiver_core_defines.svh
// assertion macros for the frame receiver core
`ifndef CHECKSUMMED_FRAME_RECEIVER_CORE_DEFINES_SVH
`define CHECKSUMMED_FRAME_RECEIVER_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define CFR_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("frame receiver check failed");

// next-cycle implication, disabled while reset is asserted
`define CFR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("frame receiver check failed");

`endif

>>> hw/rtl/cfr_pkg.sv
// shared types and constants for the frame receiver
`default_nettype none
package cfr_pkg;

	localparam int unsigned BUF_DEPTH = 64;
	localparam int unsigned MIN_FRAME = 4;
	localparam logic [7:0] FRAME_HEADER = 8'hA5;
	localparam logic [7:0] ACK_COMMAND = 8'h03;
	localparam logic CMD_RX_BYTE = 1'b0;
	localparam logic CMD_CLEAR_ACK = 1'b1;

	typedef struct packed {
		logic       command;
		logic [7:0] rx_byte;
	} item_t;

	typedef struct packed {
		logic       ack_flag;
		logic [4:0] frames_accepted;
		logic [7:0] last_frame_command;
		logic [6:0] bytes_held;
		logic       overflow;
	} result_t;

	typedef enum logic [8:0] {
		ST_IDLE   = 9'b000000001,
		ST_ENTER  = 9'b000000010,
		ST_START  = 9'b000000100,
		ST_BYTE0  = 9'b000001000,
		ST_SEARCH = 9'b000010000,
		ST_CMD    = 9'b000100000,
		ST_LEN    = 9'b001000000,
		ST_SUM    = 9'b010000000,
		ST_FIN    = 9'b100000000
	} state_t;

endpackage
`default_nettype wire

>>> hw/rtl/checksummed_frame_receiver_core.sv
// Frame receiver core: takes one received byte or one clear-acknowledge event per transfer and
// parses frames of header 0xA5, command, length L, L payload bytes and an 8-bit additive
// checksum out of a circular receive buffer of BufDepth bytes; every item yields one result.
// A clear event goes straight to the result. A byte is stored first, then the sequencer walks the
// buffer through its single read port, one byte per cycle: a parse pass may find too few bytes,
// a hunt for a header skips bytes until it meets one, header, command and length are fetched,
// and the checksum walk reads the rest of a frame. Rescans after bad frames add up to one walk
// per dropped byte. The buffer needs no clearing after reset. Results go to an output register,
// so the next item is taken while a result still waits to be transferred.
`default_nettype none
`include "checksummed_frame_receiver_core_defines.svh"
module checksummed_frame_receiver_core #(
	parameter int unsigned BufDepth = cfr_pkg::BUF_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             item_valid,
	output logic                  item_stall,
	input  wire cfr_pkg::item_t   item,
	output logic                  result_valid,
	input  wire logic             result_stall,
	output cfr_pkg::result_t      result
);

	localparam int unsigned AW = $clog2(BufDepth);
	localparam int unsigned CW = $clog2(BufDepth + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(BufDepth);
	localparam logic [CW-1:0] MIN_C = CW'(cfr_pkg::MIN_FRAME);
	localparam logic [7:0] MAX_LEN = 8'(BufDepth - cfr_pkg::MIN_FRAME);

	// circular address: base plus offset, wrapped once at the buffer depth
	function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
			input logic [CW-1:0] off);
		logic [CW:0] s;
		s = (CW+1)'(base) + (CW+1)'(off);
		if (s >= (CW+1)'(BufDepth)) begin
			s = s - (CW+1)'(BufDepth);
		end
		return s[AW-1:0];
	endfunction

	cfr_pkg::state_t state_q, state_d;
	logic [AW-1:0] head_q, head_d;
	logic [CW-1:0] count_q, count_d;
	logic [CW-1:0] idx_q, idx_d;
	logic [CW-1:0] need_q, need_d;
	logic [7:0]    rx_q, rx_d;
	logic [7:0]    fcmd_q, fcmd_d;
	logic [7:0]    sum_q, sum_d;
	logic          ack_q, ack_d;
	logic [4:0]    acc_q, acc_d;
	logic [7:0]    last_q, last_d;
	logic          ovf_q, ovf_d;
	cfr_pkg::result_t res_q;
	logic          res_valid_q;
	logic          res_load;

	logic [CW-1:0] rd_off;
	logic [CW-1:0] eff_count;
	logic [CW-1:0] len_need;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [7:0]    rd_data;
	logic          hdr_clear;

	// receive buffer
	cfr_ram #(
		.Depth (BufDepth),
		.AddrW (AW)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (rx_q),
		.raddr (wrap_add(head_q, rd_off)),
		.rdata (rd_data)
	);

	// header over non-header data empties the buffer before the byte is stored
	assign hdr_clear = (rx_q == cfr_pkg::FRAME_HEADER) && (count_q != '0)
		&& (rd_data != cfr_pkg::FRAME_HEADER);
	assign eff_count = hdr_clear ? '0 : count_q;
	assign wr_addr = wrap_add(head_q, eff_count);
	assign len_need = MIN_C + CW'(rd_data);

	assign item_stall = (state_q != cfr_pkg::ST_IDLE);

	// parse sequencer
	always_comb begin
		state_d = state_q;
		head_d = head_q;
		count_d = count_q;
		idx_d = idx_q;
		need_d = need_q;
		rx_d = rx_q;
		fcmd_d = fcmd_q;
		sum_d = sum_q;
		ack_d = ack_q;
		acc_d = acc_q;
		last_d = last_q;
		ovf_d = ovf_q;
		rd_off = '0;
		wr_en = 1'b0;
		res_load = 1'b0;
		case (state_q)
			cfr_pkg::ST_IDLE: begin
				if (item_valid) begin
					acc_d = '0;
					last_d = '0;
					ovf_d = 1'b0;
					rx_d = item.rx_byte;
					if (item.command == cfr_pkg::CMD_CLEAR_ACK) begin
						ack_d = 1'b0;
						state_d = cfr_pkg::ST_FIN;
					end else begin
						state_d = cfr_pkg::ST_ENTER;
					end
				end
			end
			cfr_pkg::ST_ENTER: begin
				if (eff_count == DEPTH_C) begin
					count_d = '0;
					ovf_d = 1'b1;
					state_d = cfr_pkg::ST_FIN;
				end else begin
					wr_en = 1'b1;
					count_d = eff_count + CW'(1);
					state_d = cfr_pkg::ST_START;
				end
			end
			cfr_pkg::ST_START: begin
				if (count_q < MIN_C) begin
					state_d = cfr_pkg::ST_FIN;
				end else begin
					state_d = cfr_pkg::ST_BYTE0;
				end
			end
			cfr_pkg::ST_BYTE0: begin
				rd_off = CW'(1);
				if (rd_data == cfr_pkg::FRAME_HEADER) begin
					state_d = cfr_pkg::ST_CMD;
				end else begin
					idx_d = CW'(1);
					state_d = cfr_pkg::ST_SEARCH;
				end
			end
			cfr_pkg::ST_SEARCH: begin
				if (idx_q >= count_q) begin
					// no header anywhere: empty the buffer
					count_d = '0;
					state_d = cfr_pkg::ST_FIN;
				end else if (rd_data == cfr_pkg::FRAME_HEADER) begin
					head_d = wrap_add(head_q, idx_q);
					count_d = count_q - idx_q;
					state_d = cfr_pkg::ST_START;
				end else begin
					idx_d = idx_q + CW'(1);
					rd_off = idx_q + CW'(1);
				end
			end
			cfr_pkg::ST_CMD: begin
				fcmd_d = rd_data;
				rd_off = CW'(2);
				state_d = cfr_pkg::ST_LEN;
			end
			cfr_pkg::ST_LEN: begin
				if (rd_data > MAX_LEN) begin
					head_d = wrap_add(head_q, CW'(1));
					count_d = count_q - CW'(1);
					state_d = cfr_pkg::ST_START;
				end else if (count_q < len_need) begin
					state_d = cfr_pkg::ST_FIN;
				end else begin
					need_d = len_need;
					sum_d = cfr_pkg::FRAME_HEADER + fcmd_q + rd_data;
					idx_d = CW'(3);
					rd_off = CW'(3);
					state_d = cfr_pkg::ST_SUM;
				end
			end
			cfr_pkg::ST_SUM: begin
				if (idx_q == need_q - CW'(1)) begin
					if (sum_q == rd_data) begin
						if (fcmd_q == cfr_pkg::ACK_COMMAND) begin
							ack_d = 1'b1;
						end
						last_d = fcmd_q;
						if (acc_q != 5'd31) begin
							acc_d = acc_q + 5'd1;
						end
						head_d = wrap_add(head_q, need_q);
						count_d = count_q - need_q;
					end else begin
						head_d = wrap_add(head_q, CW'(1));
						count_d = count_q - CW'(1);
					end
					state_d = cfr_pkg::ST_START;
				end else begin
					sum_d = sum_q + rd_data;
					idx_d = idx_q + CW'(1);
					rd_off = idx_q + CW'(1);
				end
			end
			cfr_pkg::ST_FIN: begin
				if (!res_valid_q || !result_stall) begin
					res_load = 1'b1;
					state_d = cfr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = cfr_pkg::ST_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cfr_pkg::ST_IDLE;
			head_q <= '0;
			count_q <= '0;
			ack_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q <= head_d;
			count_q <= count_d;
			ack_q <= ack_d;
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// working registers and result register
	always_ff @(posedge clk) begin
		idx_q <= idx_d;
		need_q <= need_d;
		rx_q <= rx_d;
		fcmd_q <= fcmd_d;
		sum_q <= sum_d;
		acc_q <= acc_d;
		last_q <= last_d;
		ovf_q <= ovf_d;
		if (res_load) begin
			res_q.ack_flag <= ack_q;
			res_q.frames_accepted <= acc_q;
			res_q.last_frame_command <= last_q;
			res_q.bytes_held <= 7'(count_q);
			res_q.overflow <= ovf_q;
		end
	end

	assign result_valid = res_valid_q;
	assign result = res_q;

	// checks
	`CFR_ASSERT_NOW(a_count_bound, 1'b1, count_q <= DEPTH_C)
	`CFR_ASSERT_NOW(a_head_bound, 1'b1, (CW+1)'(head_q) < (CW+1)'(BufDepth))
	`CFR_ASSERT_NOW(a_ovf_empty, result_valid && result.overflow, result.bytes_held == 7'd0)
	`CFR_ASSERT_NEXT(a_fin_loads, (state_q == cfr_pkg::ST_FIN) && !result_stall, result_valid)

endmodule
`default_nettype wire

>>> hw/rtl/cfr_ram.sv
// receive byte buffer: one write port, one registered read port
`default_nettype none
module cfr_ram #(
	parameter int unsigned Depth = cfr_pkg::BUF_DEPTH,
	parameter int unsigned AddrW = $clog2(Depth)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AddrW-1:0] waddr,
	input  wire logic [7:0]       wdata,
	input  wire logic [AddrW-1:0] raddr,
	output logic      [7:0]       rdata
);

	logic [7:0] mem [Depth];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

>>> tb/sv/tb_checksummed_frame_receiver_core.sv
// testbench for the checksummed frame receiver core: random and directed byte streams
module tb_checksummed_frame_receiver_core;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	cfr_pkg::item_t item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	cfr_pkg::result_t result;

	// stimulus and expected status
	cfr_pkg::item_t rx_events [$];
	cfr_pkg::result_t predicted_status [$];
	logic event_taken = 1'b0;
	int unsigned events_taken = 0;
	int unsigned status_seen = 0;
	int unsigned mismatches = 0;

	// receiver hold-off bookkeeping
	int unsigned hold_left = 0;
	logic hold_done = 1'b0;

	// shadow of the parser state
	logic [7:0] model_buf [cfr_pkg::BUF_DEPTH];
	int unsigned model_fill = 0;
	logic model_ack = 1'b0;

	checksummed_frame_receiver_core DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	// 20 ns clock
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// shift the shadow buffer down by n bytes
	function automatic void discard_front(int unsigned n);
		if (n >= model_fill) begin
			model_fill = 0;
		end else begin
			for (int unsigned k = 0; k < model_fill - n; k++)
				model_buf[k] = model_buf[k + n];
			model_fill -= n;
		end
	endfunction

	// status that the parser reports for one event
	function automatic cfr_pkg::result_t parse_rx_event(cfr_pkg::item_t ev);
		cfr_pkg::result_t st;
		int unsigned good_frames;
		logic [7:0] last_cmd;
		logic dropped;
		logic parsing;
		int unsigned hdr_pos;
		int unsigned need;
		logic [7:0] sum;
		good_frames = 0;
		last_cmd = 8'h00;
		dropped = 1'b0;
		if (ev.command == cfr_pkg::CMD_CLEAR_ACK) begin
			model_ack = 1'b0;
		end else begin
			// a header over junk restarts the buffer
			if (ev.rx_byte == cfr_pkg::FRAME_HEADER && model_fill > 0 &&
					model_buf[0] != cfr_pkg::FRAME_HEADER)
				model_fill = 0;
			if (model_fill >= cfr_pkg::BUF_DEPTH) begin
				model_fill = 0;
				dropped = 1'b1;
			end else begin
				model_buf[model_fill] = ev.rx_byte;
				model_fill++;
				parsing = 1'b1;
				while (parsing && model_fill >= cfr_pkg::MIN_FRAME) begin
					// hunt for the next header
					if (model_buf[0] != cfr_pkg::FRAME_HEADER) begin
						hdr_pos = 0;
						for (int unsigned k = 1; k < model_fill; k++)
							if (hdr_pos == 0 && model_buf[k] == cfr_pkg::FRAME_HEADER)
								hdr_pos = k;
						if (hdr_pos == 0) begin
							model_fill = 0;
							parsing = 1'b0;
						end else begin
							discard_front(hdr_pos);
							if (model_fill < cfr_pkg::MIN_FRAME)
								parsing = 1'b0;
						end
					end
					// length check, then checksum walk once the frame is complete
					if (parsing) begin
						if (model_buf[2] > cfr_pkg::BUF_DEPTH - cfr_pkg::MIN_FRAME) begin
							discard_front(1);
						end else begin
							need = cfr_pkg::MIN_FRAME + model_buf[2];
							if (model_fill < need) begin
								parsing = 1'b0;
							end else begin
								sum = 8'h00;
								for (int unsigned k = 0; k + 1 < need; k++)
									sum = sum + model_buf[k];
								if (sum == model_buf[need - 1]) begin
									if (model_buf[1] == cfr_pkg::ACK_COMMAND)
										model_ack = 1'b1;
									last_cmd = model_buf[1];
									if (good_frames < 31)
										good_frames++;
									discard_front(need);
								end else begin
									discard_front(1);
								end
							end
						end
					end
				end
			end
		end
		st.ack_flag = model_ack;
		st.frames_accepted = 5'(good_frames);
		st.last_frame_command = last_cmd;
		st.bytes_held = 7'(model_fill);
		st.overflow = dropped;
		return st;
	endfunction

	task automatic compare_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t: %s expected %0d got %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	task automatic queue_byte(logic [7:0] b);
		cfr_pkg::item_t ev;
		ev.command = cfr_pkg::CMD_RX_BYTE;
		ev.rx_byte = b;
		rx_events.push_back(ev);
	endtask

	task automatic queue_clear(logic [7:0] filler);
		cfr_pkg::item_t ev;
		ev.command = cfr_pkg::CMD_CLEAR_ACK;
		ev.rx_byte = filler;
		rx_events.push_back(ev);
	endtask

	// header, command, length, random payload, checksum; only the first keep bytes are sent
	task automatic queue_frame(logic [7:0] cmd, logic [7:0] len, logic good_sum,
			int unsigned keep);
		logic [7:0] sum;
		logic [7:0] b;
		int unsigned total;
		total = cfr_pkg::MIN_FRAME + len;
		sum = 8'h00;
		for (int unsigned k = 0; k < total && k < keep; k++) begin
			if (k == 0)
				b = cfr_pkg::FRAME_HEADER;
			else if (k == 1)
				b = cmd;
			else if (k == 2)
				b = len;
			else if (k == total - 1)
				b = good_sum ? sum : sum ^ 8'($urandom_range(1, 255));
			else
				b = 8'($urandom);
			sum = sum + b;
			queue_byte(b);
		end
	endtask

	// sender: offer the next event on the falling edge once the last one is taken
	always @(negedge clk) begin
		if (arst_n && (!item_valid || event_taken)) begin
			event_taken <= 1'b0;
			if (rx_events.size() != 0 &&
					((events_taken >= 500 && events_taken < 800) ||
					$urandom_range(99) >= 14)) begin
				item <= rx_events.pop_front();
				item_valid <= 1'b1;
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// receiver: random stalls, one long hold-off, a quiet stretch
	always @(negedge clk) begin
		if (hold_left != 0) begin
			result_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (!hold_done && status_seen >= 250) begin
			hold_done <= 1'b1;
			hold_left <= 300;
			result_stall <= 1'b1;
		end else if (status_seen >= 500 && status_seen < 800) begin
			result_stall <= 1'b0;
		end else begin
			result_stall <= ($urandom_range(99) < 14);
		end
	end

	// monitor: predict on each input transfer, check each output transfer
	always @(posedge clk) begin
		if (arst_n && item_valid && !item_stall) begin
			predicted_status.push_back(parse_rx_event(item));
			event_taken <= 1'b1;
			events_taken++;
		end
		if (arst_n && result_valid && !result_stall) begin
			status_seen++;
			if (predicted_status.size() == 0) begin
				$display("%0t: unexpected status transfer %h", $time, result);
				mismatches++;
			end else begin
				cfr_pkg::result_t want;
				want = predicted_status.pop_front();
				compare_field("ack_flag", want.ack_flag, result.ack_flag);
				compare_field("frames_accepted", want.frames_accepted, result.frames_accepted);
				compare_field("last_frame_command", want.last_frame_command,
					result.last_frame_command);
				compare_field("bytes_held", want.bytes_held, result.bytes_held);
				compare_field("overflow", want.overflow, result.overflow);
			end
		end
	end

	// stimulus, reset and end of run
	initial begin
		int unsigned pick;
		int unsigned len;
		int unsigned inner_len;
		logic [7:0] cmd;
		logic [7:0] sum;
		logic [7:0] b;
		logic [7:0] nested [$];

		// directed cases
		queue_clear(8'hFF);
		queue_frame(cfr_pkg::ACK_COMMAND, 8'd0, 1'b1, 4);
		queue_clear(8'h00);
		queue_frame(8'hFF, 8'd0, 1'b1, 4);
		queue_frame(8'h01, 8'd0, 1'b0, 4);
		queue_frame(8'h01, 8'd61, 1'b1, 4);
		queue_byte(8'h11);
		queue_byte(8'h22);
		queue_byte(8'h33);
		queue_byte(8'h44);
		queue_byte(8'h12);
		queue_frame(cfr_pkg::ACK_COMMAND, 8'd0, 1'b1, 4);

		// longest frames fill the buffer to its limit
		queue_frame(8'($urandom), 8'd60, 1'b1, 64);
		queue_frame(8'($urandom), 8'd60, 1'b0, 64);

		// random mix, mostly well-formed frames
		while (rx_events.size() < 1375) begin
			pick = $urandom_range(99);
			cmd = ($urandom_range(3) == 0) ? cfr_pkg::ACK_COMMAND : 8'($urandom);
			len = ($urandom_range(19) == 0) ? $urandom_range(40, 60) : $urandom_range(0, 8);
			if (pick < 50) begin
				queue_frame(cmd, 8'(len), 1'b1, cfr_pkg::MIN_FRAME + len);
			end else if (pick < 60) begin
				queue_frame(cmd, 8'(len), 1'b0, cfr_pkg::MIN_FRAME + len);
			end else if (pick < 68) begin
				queue_clear(8'($urandom));
			end else if (pick < 80) begin
				repeat ($urandom_range(1, 6))
					queue_byte(8'($urandom));
			end else if (pick < 88) begin
				queue_frame(cmd, 8'(len), 1'b1,
					$urandom_range(1, cfr_pkg::MIN_FRAME + len - 1));
			end else if (pick < 94) begin
				queue_frame(cmd, 8'($urandom_range(61, 255)), 1'b1, $urandom_range(3, 8));
			end else begin
				// frames nested in a bad outer frame, all completed by one byte
				nested.delete();
				repeat ($urandom_range(1, 3)) begin
					inner_len = $urandom_range(0, 3);
					sum = 8'h00;
					for (int unsigned k = 0; k < cfr_pkg::MIN_FRAME + inner_len; k++) begin
						if (k == 0)
							b = cfr_pkg::FRAME_HEADER;
						else if (k == 1)
							b = ($urandom_range(1) == 0) ? cfr_pkg::ACK_COMMAND : 8'($urandom);
						else if (k == 2)
							b = 8'(inner_len);
						else if (k == cfr_pkg::MIN_FRAME + inner_len - 1)
							b = sum;
						else
							b = 8'($urandom);
						sum = sum + b;
						nested.push_back(b);
					end
				end
				queue_byte(cfr_pkg::FRAME_HEADER);
				queue_byte(cmd);
				queue_byte(8'(nested.size() - 1));
				foreach (nested[k])
					queue_byte(nested[k]);
			end
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (rx_events.size() != 0 || item_valid)
			@(posedge clk);
		while (predicted_status.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (mismatches == 0 && predicted_status.size() == 0) begin
			$display("tb_checksummed_frame_receiver_core: clean");
		end else begin
			$display("tb_checksummed_frame_receiver_core: errors");
		end
		$finish;
	end

	// run limit
	initial begin
		#600ms;
		$display("tb_checksummed_frame_receiver_core: errors");
		$finish;
	end

endmodule
